FILE: src/adc_round_robin_conditioner_unit_macros.svh
// Assertion macros used by the conditioner state module.
`ifndef ADC_ROUND_ROBIN_CONDITIONER_UNIT_MACROS_SVH
`define ADC_ROUND_ROBIN_CONDITIONER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clock and disabled during reset.
`define ARRC_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("arrc same-cycle check failed");

// Next-cycle implication, sampled on clock and disabled during reset.
`define ARRC_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("arrc next-cycle check failed");

`endif

FILE: src/arrc_pkg.sv
// Shared types and constants of the ADC round-robin conditioner.
package arrc_pkg;

   typedef logic [1:0]  chan_type;
   typedef logic [11:0] sample_type;
   typedef logic [15:0] filter_type;
   typedef logic [2:0]  exp_type;
   typedef logic [6:0]  count_type;

   localparam chan_type CH_CV      = 2'd0;
   localparam chan_type CH_AUDIO_A = 2'd1;
   localparam chan_type CH_AUDIO_B = 2'd2;
   localparam chan_type CH_KNOB    = 2'd3;

   localparam int DNL_OFFSET    = 512;
   localparam int DNL_MODULUS   = 'h01FF;
   localparam int DNL_BUMP      = 4;
   localparam int SAMPLE_MAX    = 4095;
   localparam int DNL_MULT_MAX  = (SAMPLE_MAX + DNL_OFFSET) / DNL_MODULUS;

   localparam sample_type AUDIO_RESET = 12'd2048;
   localparam exp_type    EXP_MAX     = 3'd6;

   // One conditioned conversion handed to the state update.
   typedef struct packed {
      logic       valid;
      chan_type   channel;
      sample_type value;
      logic       trigger_active;
   } step_type;

   // Snapshot of all conditioned values after one step.
   typedef struct packed {
      sample_type cv_a;
      sample_type cv_b;
      sample_type knob_0;
      sample_type knob_1;
      sample_type knob_2;
      sample_type knob_3;
      sample_type audio_a;
      sample_type audio_b;
      chan_type   mux_select;
      logic       trigger_pulse;
   } result_type;

endpackage

FILE: src/adc_round_robin_conditioner_unit.sv
// A transaction accepted into the input register moves to the result register and appears on rsp_ (two registers).
// Throughput: one transaction per cycle while rsp_stall is not held; the input register and
// the result register together with the state update set this figure.
// Reset is synchronous and active high: both valid flags clear, filters go to zero,
// audio holds to mid-scale 2048, mux position, delay counter and exponent to zero.
module adc_round_robin_conditioner_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  arrc_pkg::chan_type   req_channel,
   input  arrc_pkg::sample_type req_sample,
   input  logic                 req_trigger_active,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output arrc_pkg::sample_type rsp_cv_a,
   output arrc_pkg::sample_type rsp_cv_b,
   output arrc_pkg::sample_type rsp_knob_0,
   output arrc_pkg::sample_type rsp_knob_1,
   output arrc_pkg::sample_type rsp_knob_2,
   output arrc_pkg::sample_type rsp_knob_3,
   output arrc_pkg::sample_type rsp_audio_a,
   output arrc_pkg::sample_type rsp_audio_b,
   output arrc_pkg::chan_type   rsp_mux_select,
   output logic                 rsp_trigger_pulse,
   input  logic                 csr_write_enable,
   input  arrc_pkg::exp_type    csr_write_data
);
   import arrc_pkg::*;

   logic       in_valid_ff;
   logic       in_valid_in;
   chan_type   in_channel_ff;
   sample_type in_sample_ff;
   logic       in_trigger_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   result_type rsp_data_ff;

   logic       accept;
   logic       advance;
   sample_type corrected;
   step_type   step;
   result_type result;

   // The held transaction moves on whenever the result register is empty or being drained.
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   arrc_dnl u_dnl (
      .raw       (in_sample_ff),
      .corrected (corrected)
   );

   always_comb begin
      step.valid          = advance;
      step.channel        = in_channel_ff;
      step.value          = corrected;
      step.trigger_active = in_trigger_ff;
   end

   arrc_state u_state (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .step             (step),
      .result           (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_channel_ff <= req_channel;
         in_sample_ff  <= req_sample;
         in_trigger_ff <= req_trigger_active;
      end
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cv_a          = rsp_data_ff.cv_a;
   assign rsp_cv_b          = rsp_data_ff.cv_b;
   assign rsp_knob_0        = rsp_data_ff.knob_0;
   assign rsp_knob_1        = rsp_data_ff.knob_1;
   assign rsp_knob_2        = rsp_data_ff.knob_2;
   assign rsp_knob_3        = rsp_data_ff.knob_3;
   assign rsp_audio_a       = rsp_data_ff.audio_a;
   assign rsp_audio_b       = rsp_data_ff.audio_b;
   assign rsp_mux_select    = rsp_data_ff.mux_select;
   assign rsp_trigger_pulse = rsp_data_ff.trigger_pulse;

endmodule

FILE: src/arrc_dnl.sv
// DNL correction of one raw 12-bit ADC conversion.
module arrc_dnl (
   input  arrc_pkg::sample_type raw,
   output arrc_pkg::sample_type corrected
);
   import arrc_pkg::*;

   logic [12:0] shifted;
   logic        hit;
   logic [12:0] sum;

   always_comb begin
      shifted = {1'b0, raw} + 13'(DNL_OFFSET);
      // The offset sample is a multiple of the modulus for only a handful of values.
      hit = 1'b0;
      for (int k = 1; k <= DNL_MULT_MAX; k++) begin
         if (shifted == 13'(k * DNL_MODULUS)) begin
            hit = 1'b1;
         end
      end
      sum = {1'b0, raw} + (hit ? 13'(DNL_BUMP) : 13'd0)
            - {7'b0, shifted[12:10], 3'b000};
      corrected = sum[11:0];
   end

endmodule

FILE: src/arrc_state.sv
// Filter, audio hold, mux position and trigger delay state with its update.
module arrc_state (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  arrc_pkg::exp_type    csr_write_data,
   input  arrc_pkg::step_type   step,
   output arrc_pkg::result_type result
);
   import arrc_pkg::*;
   `include "adc_round_robin_conditioner_unit_macros.svh"

   exp_type    exp_ff;
   filter_type cv_filter_ff [2];
   filter_type cv_filter_in [2];
   filter_type knob_filter_ff [4];
   filter_type knob_filter_in [4];
   sample_type audio_hold_ff [2];
   sample_type audio_hold_in [2];
   chan_type   mux_pos_ff;
   chan_type   mux_pos_in;
   count_type  delay_count_ff;
   count_type  delay_count_in;

   filter_type  cv_cur;
   filter_type  knob_cur;
   logic [19:0] cv_sum;
   logic [23:0] knob_sum;
   exp_type     exp_sat;
   count_type   load_value;
   count_type   count_mid;
   logic        pulse;

   always_comb begin
      cv_filter_in   = cv_filter_ff;
      knob_filter_in = knob_filter_ff;
      audio_hold_in  = audio_hold_ff;
      mux_pos_in     = mux_pos_ff;
      delay_count_in = delay_count_ff;
      pulse          = 1'b0;

      cv_cur   = cv_filter_ff[mux_pos_ff[0]];
      knob_cur = knob_filter_ff[mux_pos_ff];
      cv_sum   = ({4'b0, cv_cur} << 3) - {4'b0, cv_cur} + {4'b0, step.value, 4'b0000};
      knob_sum = ({8'b0, knob_cur} << 7) - {8'b0, knob_cur}
                 + {8'b0, step.value, 4'b0000};

      exp_sat    = (exp_ff > EXP_MAX) ? EXP_MAX : exp_ff;
      load_value = (exp_sat == 3'd0) ? 7'd1 : ((7'd1 << exp_sat) + 7'd1);
      count_mid  = step.trigger_active ? load_value : delay_count_ff;

      if (step.valid) begin
         unique case (step.channel)
            CH_CV: begin
               cv_filter_in[mux_pos_ff[0]] = cv_sum[18:3];
            end
            CH_AUDIO_A: begin
               audio_hold_in[0] = step.value;
            end
            CH_AUDIO_B: begin
               audio_hold_in[1] = step.value;
            end
            CH_KNOB: begin
               knob_filter_in[mux_pos_ff] = knob_sum[22:7];
               mux_pos_in = mux_pos_ff + 2'd1;
               delay_count_in = count_mid;
               if (count_mid != 7'd0) begin
                  delay_count_in = count_mid - 7'd1;
                  pulse = (delay_count_in == 7'd0);
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_ff            <= 3'd0;
         cv_filter_ff[0]   <= '0;
         cv_filter_ff[1]   <= '0;
         knob_filter_ff[0] <= '0;
         knob_filter_ff[1] <= '0;
         knob_filter_ff[2] <= '0;
         knob_filter_ff[3] <= '0;
         audio_hold_ff[0]  <= AUDIO_RESET;
         audio_hold_ff[1]  <= AUDIO_RESET;
         mux_pos_ff        <= 2'd0;
         delay_count_ff    <= 7'd0;
      end else begin
         if (csr_write_enable) begin
            exp_ff <= csr_write_data;
         end
         cv_filter_ff   <= cv_filter_in;
         knob_filter_ff <= knob_filter_in;
         audio_hold_ff  <= audio_hold_in;
         mux_pos_ff     <= mux_pos_in;
         delay_count_ff <= delay_count_in;
      end
   end

   // The snapshot reflects the state after this step.
   assign result.cv_a          = cv_filter_in[0][15:4];
   assign result.cv_b          = cv_filter_in[1][15:4];
   assign result.knob_0        = knob_filter_in[0][15:4];
   assign result.knob_1        = knob_filter_in[1][15:4];
   assign result.knob_2        = knob_filter_in[2][15:4];
   assign result.knob_3        = knob_filter_in[3][15:4];
   assign result.audio_a       = audio_hold_in[0];
   assign result.audio_b       = audio_hold_in[1];
   assign result.mux_select    = mux_pos_in;
   assign result.trigger_pulse = pulse;

   `ARRC_ASSERT_NXT(a_mux_hold, step.valid && step.channel != CH_KNOB, $stable(mux_pos_ff))
   `ARRC_ASSERT_NXT(a_mux_advance, step.valid && step.channel == CH_KNOB,
                    mux_pos_ff == $past(mux_pos_ff) + 2'd1)
   `ARRC_ASSERT_IMP(a_pulse_knob_only, pulse, step.valid && step.channel == CH_KNOB)
   `ARRC_ASSERT_IMP(a_pulse_no_delay,
                    step.valid && step.channel == CH_KNOB && step.trigger_active
                    && exp_ff == 3'd0, pulse)

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the ADC round-robin conditioner unit.
module tb_top;
   import arrc_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DNL_OFFSET_TB = 512;
   localparam int DNL_STEP = 511;
   localparam int DELAY_EXP_CAP = 6;
   localparam int NUM_PHASES = 8;
   localparam sample_type AUDIO_MID = 12'd2048;

   typedef struct packed {
      chan_type   channel;
      sample_type raw;
      logic       trig;
   } conversion_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   chan_type   req_channel = CH_CV;
   sample_type req_sample = '0;
   logic       req_trigger_active = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   sample_type rsp_cv_a, rsp_cv_b, rsp_knob_0, rsp_knob_1, rsp_knob_2, rsp_knob_3;
   sample_type rsp_audio_a, rsp_audio_b;
   chan_type   rsp_mux_select;
   logic       rsp_trigger_pulse;
   logic       csr_write_enable = 1'b0;
   exp_type    csr_write_data = '0;

   // Private copy of the conditioner state used for prediction.
   logic [15:0] cv_state [2];
   logic [15:0] knob_state [4];
   sample_type  audio_state [2];
   chan_type    mux_pos;
   logic [6:0]  delay_left;
   exp_type     exp_setting;

   conversion_type conv_pending [$];
   result_type  snapshot_expected [$];
   int          items_queued = 0;
   int          results_seen = 0;
   int          fail_count = 0;
   int          pulse_count = 0;
   int          bump_count = 0;
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   int          quiet_cycles = 0;
   bit          req_taken = 1'b0;
   chan_type    rr_channel = CH_CV;

   int unsigned phase_exp [NUM_PHASES] = '{1, 6, 7, 0, 3, 2, 5, 4};
   int          phase_len [NUM_PHASES] = '{120, 200, 200, 120, 120, 120, 120, 120};

   adc_round_robin_conditioner_unit i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_channel        (req_channel),
      .req_sample         (req_sample),
      .req_trigger_active (req_trigger_active),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_cv_a           (rsp_cv_a),
      .rsp_cv_b           (rsp_cv_b),
      .rsp_knob_0         (rsp_knob_0),
      .rsp_knob_1         (rsp_knob_1),
      .rsp_knob_2         (rsp_knob_2),
      .rsp_knob_3         (rsp_knob_3),
      .rsp_audio_a        (rsp_audio_a),
      .rsp_audio_b        (rsp_audio_b),
      .rsp_mux_select     (rsp_mux_select),
      .rsp_trigger_pulse  (rsp_trigger_pulse),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   always #1 clock = ~clock;

   // Applies one conversion to the private state and returns the snapshot it yields.
   function automatic result_type predict_snapshot(chan_type ch, sample_type raw, logic trg);
      int         offs;
      int         fixed;
      int         cap_exp;
      logic       pulse;
      result_type snap;
      pulse = 1'b0;
      offs = int'(raw) + DNL_OFFSET_TB;
      fixed = int'(raw);
      if (offs % DNL_STEP == 0) begin
         fixed = fixed + 4;
         bump_count++;
      end
      fixed = fixed - ((offs >> 10) << 3);
      case (ch)
         CH_CV: begin
            cv_state[mux_pos[0]] = 16'((7 * int'(cv_state[mux_pos[0]]) + 16 * fixed) >> 3);
         end
         CH_AUDIO_A: begin
            audio_state[0] = sample_type'(fixed);
         end
         CH_AUDIO_B: begin
            audio_state[1] = sample_type'(fixed);
         end
         default: begin
            knob_state[mux_pos] = 16'((127 * int'(knob_state[mux_pos]) + 16 * fixed) >> 7);
            mux_pos = mux_pos + 2'd1;
            if (trg) begin
               cap_exp = (int'(exp_setting) > DELAY_EXP_CAP) ? DELAY_EXP_CAP
                                                              : int'(exp_setting);
               delay_left = (cap_exp != 0) ? 7'((1 << cap_exp) + 1) : 7'd1;
            end
            if (delay_left != 7'd0) begin
               delay_left = delay_left - 7'd1;
               if (delay_left == 7'd0) begin
                  pulse = 1'b1;
                  pulse_count++;
               end
            end
         end
      endcase
      snap.cv_a = cv_state[0][15:4];
      snap.cv_b = cv_state[1][15:4];
      snap.knob_0 = knob_state[0][15:4];
      snap.knob_1 = knob_state[1][15:4];
      snap.knob_2 = knob_state[2][15:4];
      snap.knob_3 = knob_state[3][15:4];
      snap.audio_a = audio_state[0];
      snap.audio_b = audio_state[1];
      snap.mux_select = mux_pos;
      snap.trigger_pulse = pulse;
      return snap;
   endfunction

   task automatic check_field(string name, logic [11:0] want, logic [11:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   task automatic queue_conversion(chan_type ch, int raw, bit trg);
      conversion_type conv;
      conv.channel = ch;
      conv.raw = sample_type'(raw);
      conv.trig = trg;
      conv_pending.push_back(conv);
      items_queued++;
   endtask

   // Mostly an in-order scan with random content; a fifth of the channels are random.
   task automatic queue_random_scan(int count);
      chan_type ch;
      int       raw;
      int       span;
      bit       trg;
      span = (exp_setting == 3'd0) ? 1 :
             (1 << ((int'(exp_setting) > DELAY_EXP_CAP) ? DELAY_EXP_CAP : int'(exp_setting)));
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 4) == 0) begin
            ch = chan_type'($urandom_range(0, 3));
         end else begin
            ch = rr_channel;
         end
         rr_channel = ch + 2'd1;
         case ($urandom_range(0, 9))
            0: raw = DNL_STEP * int'($urandom_range(2, 9)) - DNL_OFFSET_TB;
            1: raw = 1024 * int'($urandom_range(1, 4)) - DNL_OFFSET_TB
                     - int'($urandom_range(0, 1));
            2: raw = 4095;
            3: raw = 0;
            default: raw = int'($urandom_range(0, 4095));
         endcase
         if (ch == CH_KNOB) begin
            trg = ($urandom_range(0, span) == 0);
         end else begin
            trg = 1'($urandom_range(0, 1));
         end
         queue_conversion(ch, raw, trg);
      end
   endtask

   task automatic drain_and_settle();
      while (results_seen != items_queued) begin
         @(negedge clock);
      end
      repeat (3) @(negedge clock);
   endtask

   task automatic set_delay_exponent(exp_type value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      exp_setting = value;
   endtask

   // Driver: presents the next pending conversion once the previous one was taken.
   always @(negedge clock) begin
      conversion_type next_conv;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (conv_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            next_conv = conv_pending.pop_front();
            req_valid <= 1'b1;
            req_channel <= next_conv.channel;
            req_sample <= next_conv.raw;
            req_trigger_active <= next_conv.trig;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // Monitor: checks each result transaction, then predicts for each accepted request.
   always @(posedge clock) begin
      result_type want;
      req_taken = 1'b0;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (snapshot_expected.size() == 0) begin
               $error("result transaction arrived with no expected snapshot");
               fail_count++;
            end else begin
               want = snapshot_expected.pop_front();
               check_field("cv_a", want.cv_a, rsp_cv_a);
               check_field("cv_b", want.cv_b, rsp_cv_b);
               check_field("knob_0", want.knob_0, rsp_knob_0);
               check_field("knob_1", want.knob_1, rsp_knob_1);
               check_field("knob_2", want.knob_2, rsp_knob_2);
               check_field("knob_3", want.knob_3, rsp_knob_3);
               check_field("audio_a", want.audio_a, rsp_audio_a);
               check_field("audio_b", want.audio_b, rsp_audio_b);
               check_field("mux_select", 12'(want.mux_select), 12'(rsp_mux_select));
               check_field("trigger_pulse", 12'(want.trigger_pulse), 12'(rsp_trigger_pulse));
            end
         end
         if (req_valid && !req_stall) begin
            req_taken = 1'b1;
            snapshot_expected.push_back(
               predict_snapshot(req_channel, req_sample, req_trigger_active));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          csr_write_enable) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $error("no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      foreach (cv_state[i]) cv_state[i] = '0;
      foreach (knob_state[i]) knob_state[i] = '0;
      foreach (audio_state[i]) audio_state[i] = AUDIO_MID;
      mux_pos = '0;
      delay_left = '0;
      exp_setting = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      set_delay_exponent(3'd0);

      // Directed: field extremes, DNL bump points and shift boundaries, CV on every
      // mux position, trigger ignored off the knob channel, immediate pulse at exponent 0.
      queue_conversion(CH_CV, 4095, 1);       queue_conversion(CH_AUDIO_A, 0, 1);
      queue_conversion(CH_AUDIO_B, 4095, 0);  queue_conversion(CH_KNOB, 4095, 1);
      queue_conversion(CH_CV, 0, 0);          queue_conversion(CH_AUDIO_A, 510, 0);
      queue_conversion(CH_AUDIO_B, 4087, 1);  queue_conversion(CH_KNOB, 0, 0);
      queue_conversion(CH_CV, 2043, 0);       queue_conversion(CH_AUDIO_A, 3584, 0);
      queue_conversion(CH_AUDIO_B, 3583, 0);  queue_conversion(CH_KNOB, 1021, 1);
      queue_conversion(CH_CV, 4087, 0);       queue_conversion(CH_AUDIO_A, 511, 0);
      queue_conversion(CH_AUDIO_B, 512, 0);   queue_conversion(CH_KNOB, 2554, 0);
      queue_conversion(CH_KNOB, 4095, 1);     queue_conversion(CH_KNOB, 4095, 1);
      queue_conversion(CH_KNOB, 3065, 0);     queue_conversion(CH_KNOB, 3576, 1);
      queue_conversion(CH_CV, 1532, 1);       queue_conversion(CH_AUDIO_A, 1535, 0);
      queue_conversion(CH_AUDIO_B, 1536, 0);  queue_conversion(CH_KNOB, 2560, 0);
      drain_and_settle();

      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 47; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 47; end
            default: begin send_idle_pct = 33; stall_pct = 33; end
         endcase
         set_delay_exponent(exp_type'(phase_exp[p]));
         queue_random_scan(phase_len[p]);
         // The sender stops here until every expected snapshot has come back.
         drain_and_settle();
      end

      $display("Covered %0d conversions over %0d delay exponent settings including 7.",
               items_queued, NUM_PHASES + 1);
      $display("Predicted %0d trigger pulses and %0d DNL bump corrections.",
               pulse_count, bump_count);
      if (snapshot_expected.size() != 0) begin
         $error("%0d expected snapshots never arrived", snapshot_expected.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
